// ===== src/msb_first_bit_reader_unit_assert.svh =====
// Assertion macros shared by the reader RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef MSB_FIRST_BIT_READER_UNIT_ASSERT_SVH
`define MSB_FIRST_BIT_READER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define MBRU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MBRU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define MBRU_ASSERT(lbl, prop, msg)

`define MBRU_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== src/mbru_pkg.sv =====
package mbru_pkg;

    // Default buffer size in bytes.
    localparam int BUF_BYTES_DEF = 4096;

    // Largest bit count for one get or peek.
    localparam int MAX_GET = 64;

    // Operation codes.
    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_SETLEN = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_PEEK   = 3'd3;
    localparam logic [2:0] OP_SKIP   = 3'd4;
    localparam logic [2:0] OP_SEEK   = 3'd5;
    localparam logic [2:0] OP_TELL   = 3'd6;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Control from the sequencer to the byte gather unit.
    typedef struct packed {
        logic       clear;  // start a new gather
        logic       shift;  // append the byte on the read port
        logic [2:0] tail;   // bits to drop below the wanted field
        logic [6:0] take;   // width of the wanted field
    } t_ext_ctl;

endpackage

// ===== src/msb_first_bit_reader_unit.sv =====
// Channel   Handshake                    Payload
// -------   ---------------------------  ------------------------------------------
// in        i_in_valid / o_in_stall      i_operation, i_byte_index, i_byte_value, i_count
// out       o_out_valid / i_out_stall    o_bits_value, o_position, o_remaining, o_status
//
// Every beat except get and peek runs the execute then the done state to the result register.
// Get and peek read the buffer one byte per cycle through the single memory read port,
// fetching each byte spanned by the field (1 to 9 bytes), then pass drain and done; a zero-bit
// field or a count above 64 reads nothing and goes from execute straight to done.
// Reset is synchronous, active low; it clears position, length and the sequencer.
// The buffer is not cleared. A stalled result holds the block in its last step.
module msb_first_bit_reader_unit #(
    parameter int BUF_BYTES = mbru_pkg::BUF_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [11:0] i_byte_index,
    input  logic [7:0]  i_byte_value,
    input  logic [15:0] i_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_bits_value,
    output logic [15:0] o_position,
    output logic [15:0] o_remaining,
    output logic [1:0]  o_status
);

    import mbru_pkg::*;

    `include "msb_first_bit_reader_unit_assert.svh"

    localparam int          AW      = $clog2(BUF_BYTES);
    localparam logic [31:0] LEN_MAX = 32'(BUF_BYTES) * 32'd8;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_FETCH = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic [2:0]      r_op, n_op;
    logic [11:0]     r_idx, n_idx;
    logic [7:0]      r_val, n_val;
    logic [15:0]     r_cnt, n_cnt;
    logic [15:0]     r_pos, n_pos;
    logic [15:0]     r_len, n_len;
    logic [6:0]      r_take, n_take;
    logic [2:0]      r_tail, n_tail;
    logic [3:0]      r_issue, n_issue;
    logic            r_rd_pend, n_rd_pend;
    logic            r_gather, n_gather;
    logic [1:0]      r_status, n_status;
    logic [63:0]     r_rslt, n_rslt;
    logic [AW-1:0]   r_addr, n_addr;
    logic            r_out_vld, n_out_vld;
    logic [63:0]     r_o_bits, n_o_bits;
    logic [15:0]     r_o_pos, n_o_pos;
    logic [15:0]     r_o_rem, n_o_rem;
    logic [1:0]      r_o_status, n_o_status;

    logic [15:0]     left;
    logic [15:0]     take_full;
    logic [6:0]      take_get;
    logic            short;
    logic            cnt_bad;
    logic [7:0]      span;
    logic [7:0]      span_up;
    logic [15:0]     len_sat;
    logic            mem_we;
    logic [7:0]      rd_byte;
    logic [63:0]     ext_bits;
    t_ext_ctl        ext_ctl;

    // Byte buffer.
    mbru_store #(
        .BUF_BYTES (BUF_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(r_idx)),
        .i_wdata (r_val),
        .i_raddr (r_addr),
        .o_rdata (rd_byte)
    );

    // Shared gather and align unit.
    mbru_extract u_extract (
        .i_clk  (i_clk),
        .i_ctl  (ext_ctl),
        .i_byte (rd_byte),
        .o_bits (ext_bits)
    );

    // Quantities derived from the current position and the held beat.
    always_comb begin
        left      = r_len - r_pos;
        short     = r_cnt > left;
        take_full = short ? left : r_cnt;
        take_get  = take_full[6:0];
        cnt_bad   = r_cnt > 16'(MAX_GET);
        span      = {5'b0, r_pos[2:0]} + {1'b0, take_get};
        span_up   = span + 8'd7;
        if ({16'b0, r_cnt} > LEN_MAX) begin
            len_sat = LEN_MAX[15:0];
        end else begin
            len_sat = r_cnt;
        end
    end

    assign mem_we = (r_state == S_EXEC) && (r_op == OP_LOAD)
                    && ({20'b0, r_idx} < 32'(BUF_BYTES));

    assign ext_ctl.clear = (r_state == S_EXEC);
    assign ext_ctl.shift = r_rd_pend;
    assign ext_ctl.tail  = r_tail;
    assign ext_ctl.take  = r_take;

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_idx      = r_idx;
        n_val      = r_val;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_len      = r_len;
        n_take     = r_take;
        n_tail     = r_tail;
        n_issue    = r_issue;
        n_rd_pend  = r_rd_pend;
        n_gather   = r_gather;
        n_status   = r_status;
        n_rslt     = r_rslt;
        n_addr     = r_addr;
        n_out_vld  = r_out_vld;
        n_o_bits   = r_o_bits;
        n_o_pos    = r_o_pos;
        n_o_rem    = r_o_rem;
        n_o_status = r_o_status;

        // A result taken downstream frees the output register.
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_operation;
                    n_idx   = i_byte_index;
                    n_val   = i_byte_value;
                    n_cnt   = i_count;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status  = ST_OK;
                n_rslt    = '0;
                n_gather  = 1'b0;
                n_rd_pend = 1'b0;
                n_state   = S_DONE;
                case (r_op)
                    OP_LOAD: begin
                        // The write happens through mem_we.
                    end
                    OP_SETLEN: begin
                        n_len = len_sat;
                        n_pos = '0;
                    end
                    OP_GET, OP_PEEK: begin
                        if (cnt_bad) begin
                            n_status = ST_INVALID;
                        end else begin
                            if (short) begin
                                n_status = ST_SHORT;
                            end
                            if (take_get != 7'd0) begin
                                n_gather = 1'b1;
                                n_take   = take_get;
                                n_tail   = 3'd0 - span[2:0];
                                n_addr   = AW'(r_pos >> 3);
                                n_issue  = span_up[6:3];
                                n_state  = S_FETCH;
                            end
                            if (r_op == OP_GET) begin
                                n_pos = r_pos + {9'b0, take_get};
                            end
                        end
                    end
                    OP_SKIP: begin
                        n_pos  = r_pos + take_full;
                        n_rslt = {48'b0, take_full};
                    end
                    OP_SEEK: begin
                        if (r_cnt > r_len) begin
                            n_status = ST_INVALID;
                        end else begin
                            n_pos = r_cnt;
                        end
                    end
                    OP_TELL: begin
                        // Reports position and remaining only.
                    end
                    default: begin
                        n_status = ST_INVALID;
                    end
                endcase
            end
            S_FETCH: begin
                // Issue one byte read per cycle; the previous byte is appended meanwhile.
                n_addr    = r_addr + AW'(1);
                n_issue   = r_issue - 4'd1;
                n_rd_pend = 1'b1;
                if (r_issue == 4'd1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_rd_pend = 1'b0;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld  = 1'b1;
                    n_o_bits   = r_gather ? ext_bits : r_rslt;
                    n_o_pos    = r_pos;
                    n_o_rem    = r_len - r_pos;
                    n_o_status = r_status;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_len     <= '0;
            r_issue   <= '0;
            r_rd_pend <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_issue   <= n_issue;
            r_rd_pend <= n_rd_pend;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_idx      <= n_idx;
        r_val      <= n_val;
        r_cnt      <= n_cnt;
        r_take     <= n_take;
        r_tail     <= n_tail;
        r_gather   <= n_gather;
        r_status   <= n_status;
        r_rslt     <= n_rslt;
        r_addr     <= n_addr;
        r_o_bits   <= n_o_bits;
        r_o_pos    <= n_o_pos;
        r_o_rem    <= n_o_rem;
        r_o_status <= n_o_status;
    end

    assign o_in_stall   = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid  = r_out_vld;
    assign o_bits_value = r_o_bits;
    assign o_position   = r_o_pos;
    assign o_remaining  = r_o_rem;
    assign o_status     = r_o_status;

    // Checks on the sequencer and the position bookkeeping.
    `MBRU_ASSERT(a_pos_in_len, r_pos <= r_len, "read position beyond stream length")
    `MBRU_ASSERT(a_fetch_count,
        (r_state == S_FETCH) |-> (r_issue != 4'd0) && (r_issue <= 4'd9),
        "byte fetch count out of range")
    `MBRU_ASSERT(a_fetch_take,
        (r_state == S_FETCH) |-> (r_take != 7'd0) && (r_take <= 7'd64),
        "gather width out of range")
    `MBRU_ASSERT(a_accept_exec,
        (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC),
        "accepted beat not executed")
    `MBRU_ASSERT_ALWAYS(a_reset_idle,
        !i_rst_n |=> (r_state == S_IDLE) && !o_out_valid,
        "reset left the block busy")

endmodule

// ===== src/mbru_store.sv =====
module mbru_store #(
    parameter int BUF_BYTES = mbru_pkg::BUF_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(BUF_BYTES)-1:0] i_waddr,
    input  logic [7:0]                   i_wdata,
    input  logic [$clog2(BUF_BYTES)-1:0] i_raddr,
    output logic [7:0]                   o_rdata
);

    logic [7:0] mem [BUF_BYTES];
    logic [7:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/mbru_extract.sv =====
module mbru_extract (
    input  logic              i_clk,
    input  mbru_pkg::t_ext_ctl i_ctl,
    input  logic [7:0]        i_byte,
    output logic [63:0]       o_bits
);

    import mbru_pkg::*;

    logic [71:0] r_acc;
    logic [71:0] n_acc;
    logic [71:0] algn;
    logic [63:0] mask;

    // Shift register that collects up to nine bytes, first byte on top.
    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_ctl.shift) begin
            n_acc = {r_acc[63:0], i_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // Drop the bits behind the field, then keep only the field itself.
    always_comb begin
        algn = r_acc >> i_ctl.tail;
        if (i_ctl.take >= 7'(MAX_GET)) begin
            mask = '1;
        end else begin
            mask = (64'd1 << i_ctl.take) - 64'd1;
        end
    end

    assign o_bits = algn[63:0] & mask;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import mbru_pkg::*;

    // Operation code with no meaning to the block.
    localparam logic [2:0] OP_UNDEF = 3'd7;

    localparam int BUF_BYTES    = BUF_BYTES_DEF;
    localparam int MAX_BITS     = BUF_BYTES * 8;
    localparam int RANDOM_BEATS = 1900;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PREFIX_CAP   = 600;

    typedef struct packed {
        logic [2:0]  op;
        logic [11:0] idx;
        logic [7:0]  val;
        logic [15:0] cnt;
    } beat_t;

    typedef struct packed {
        logic [63:0] bits;
        logic [15:0] pos;
        logic [15:0] rem;
        logic [1:0]  st;
    } outcome_t;

    typedef struct packed {
        beat_t    b;
        logic     typed;
        outcome_t want;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_operation = '0;
    logic [11:0] i_byte_index = '0;
    logic [7:0]  i_byte_value = '0;
    logic [15:0] i_count = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [63:0] o_bits_value;
    logic [15:0] o_position;
    logic [15:0] o_remaining;
    logic [1:0]  o_status;

    msb_first_bit_reader_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_byte_index (i_byte_index),
        .i_byte_value (i_byte_value),
        .i_count      (i_count),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_bits_value (o_bits_value),
        .o_position   (o_position),
        .o_remaining  (o_remaining),
        .o_status     (o_status)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the reader state.
    logic [7:0]  mem_bytes [0:BUF_BYTES-1];
    bit          byte_known [0:BUF_BYTES-1];
    int unsigned cur_pos = 0;
    int unsigned bit_len = 0;
    int          prefix_bytes = 0;

    outcome_t    expected_results [$];
    dir_row_t    dir_rows [$];
    int          fail_count = 0;
    int          beats_sent = 0;
    int          cycle_count = 0;
    bit          in_burst = 1'b0;
    int          stall_run = 0;
    int          open_run = 0;

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 12);
        else return $urandom_range(20, 40);
    endfunction

    // Collects take bits MSB-first from the shadow buffer, right-aligned.
    function automatic logic [63:0] gather_bits(int unsigned start, int unsigned take);
        logic [63:0] acc;
        int unsigned p;
        acc = '0;
        for (int unsigned i = 0; i < take; i++) begin
            p = start + i;
            acc = {acc[62:0], mem_bytes[p >> 3][7 - (p & 7)]};
        end
        return acc;
    endfunction

    // Applies one beat to the shadow state and returns the result it yields.
    function automatic outcome_t reader_predict(beat_t b);
        outcome_t    res;
        int unsigned left;
        int unsigned take;
        int unsigned cnt;
        left = bit_len - cur_pos;
        cnt = 32'(b.cnt);
        res.bits = '0;
        res.st = ST_OK;
        case (b.op)
            OP_LOAD: begin
                mem_bytes[b.idx] = b.val;
                byte_known[b.idx] = 1'b1;
            end
            OP_SETLEN: begin
                bit_len = (cnt > MAX_BITS) ? MAX_BITS : cnt;
                cur_pos = 0;
            end
            OP_GET, OP_PEEK: begin
                if (cnt > MAX_GET) begin
                    res.st = ST_INVALID;
                end else begin
                    take = cnt;
                    if (take > left) begin
                        take = left;
                        res.st = ST_SHORT;
                    end
                    res.bits = gather_bits(cur_pos, take);
                    if (b.op == OP_GET) cur_pos += take;
                end
            end
            OP_SKIP: begin
                take = (cnt > left) ? left : cnt;
                cur_pos += take;
                res.bits = 64'(take);
            end
            OP_SEEK: begin
                if (cnt > bit_len) res.st = ST_INVALID;
                else cur_pos = cnt;
            end
            OP_TELL: ;
            default: res.st = ST_INVALID;
        endcase
        res.pos = cur_pos[15:0];
        res.rem = 16'(bit_len - cur_pos);
        return res;
    endfunction

    // Bits readable from pos before the first byte that was never loaded, capped at a get.
    function automatic int unsigned readable_bits(int unsigned pos);
        int unsigned n;
        int unsigned p;
        int unsigned step;
        n = 0;
        p = pos;
        while (n < MAX_GET && (p >> 3) < BUF_BYTES && byte_known[p >> 3]) begin
            step = 8 - (p & 7);
            n += step;
            p += step;
        end
        return (n > MAX_GET) ? MAX_GET : n;
    endfunction

    function automatic dir_row_t mk_row(logic [2:0] op, logic [11:0] idx, logic [7:0] val,
                                        logic [15:0] cnt, int typed, logic [63:0] bits,
                                        logic [15:0] pos, logic [15:0] rem, logic [1:0] st);
        dir_row_t row;
        row.b = '{op: op, idx: idx, val: val, cnt: cnt};
        row.typed = (typed != 0);
        row.want = '{bits: bits, pos: pos, rem: rem, st: st};
        return row;
    endfunction

    function automatic beat_t rand_beat(logic [2:0] op);
        beat_t b;
        b.op = op;
        b.idx = 12'($urandom_range(0, BUF_BYTES - 1));
        b.val = 8'($urandom_range(0, 255));
        b.cnt = 16'($urandom_range(0, 65535));
        return b;
    endfunction

    // Presents one beat, waits for it to be taken and records what it should produce.
    task automatic send_beat(beat_t b, logic typed, outcome_t want);
        int       gap;
        outcome_t got;
        gap = in_burst ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= b.op;
        i_byte_index <= b.idx;
        i_byte_value <= b.val;
        i_count      <= b.cnt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        got = reader_predict(b);
        expected_results.push_back(typed ? want : got);
        beats_sent++;
    endtask

    // One sequence: fill some bytes, set a length, then read around in it, with some bad beats.
    task automatic run_session();
        int          n_load;
        int          n_ops;
        int          r;
        int unsigned left;
        int unsigned take;
        int unsigned room;
        beat_t       b;
        in_burst = ($urandom_range(0, 3) == 0);

        // Grow or rewrite the loaded prefix, sometimes touching the top of the buffer.
        n_load = $urandom_range(1, 12);
        for (int k = 0; k < n_load; k++) begin
            b = rand_beat(OP_LOAD);
            r = $urandom_range(0, 99);
            if (r < 8) b.idx = 12'($urandom_range(BUF_BYTES / 2, BUF_BYTES - 1));
            else if (r < 45 || prefix_bytes >= PREFIX_CAP)
                b.idx = 12'($urandom_range(0, prefix_bytes - 1));
            else b.idx = 12'(prefix_bytes);
            send_beat(b, 1'b0, '0);
            while (prefix_bytes < BUF_BYTES && byte_known[prefix_bytes]) prefix_bytes++;
        end

        // New stream length, mostly inside the loaded prefix.
        b = rand_beat(OP_SETLEN);
        r = $urandom_range(0, 99);
        if (r < 25) b.cnt = 16'(prefix_bytes * 8);
        else if (r >= 35) b.cnt = 16'($urandom_range(0, prefix_bytes * 8));
        send_beat(b, 1'b0, '0);

        n_ops = $urandom_range(4, 24);
        repeat (n_ops) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                b = rand_beat((r < 30) ? OP_GET : OP_PEEK);
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 3))
                        0: b.cnt = '0;
                        1: b.cnt = 16'd1;
                        2: b.cnt = 16'(MAX_GET - 1);
                        default: b.cnt = 16'(MAX_GET);
                    endcase
                end else begin
                    b.cnt = 16'($urandom_range(0, MAX_GET));
                end
                // Keep every read inside bytes that hold loaded data.
                left = bit_len - cur_pos;
                take = (32'(b.cnt) > left) ? left : 32'(b.cnt);
                room = readable_bits(cur_pos);
                if (take > room) b.cnt = 16'(room);
            end else if (r < 64) begin
                b = rand_beat(OP_SKIP);
                if ($urandom_range(0, 9) != 0) b.cnt = 16'($urandom_range(0, 80));
            end else if (r < 78) begin
                b = rand_beat(OP_SEEK);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: b.cnt = 16'($urandom_range(0, bit_len));
                    7: b.cnt = 16'(bit_len);
                    default: ;
                endcase
            end else if (r < 85) begin
                b = rand_beat(OP_TELL);
            end else if (r < 88) begin
                b = rand_beat(OP_SETLEN);
                b.cnt = 16'(bit_len);
            end else if (r < 93) begin
                b = rand_beat(OP_UNDEF);
            end else begin
                // Counts above a full get are rejected before any read.
                b = rand_beat(($urandom_range(0, 1) == 0) ? OP_GET : OP_PEEK);
                b.cnt = 16'($urandom_range(MAX_GET + 1, 65535));
            end
            send_beat(b, 1'b0, '0);
        end
    endtask

    task automatic check_result();
        outcome_t want;
        if (expected_results.size() == 0) begin
            $error("unexpected result beat: bits_value=%h position=%0d", o_bits_value,
                   o_position);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            if (o_bits_value !== want.bits) begin
                $error("bits_value: expected %h, got %h", want.bits, o_bits_value);
                fail_count++;
            end
            if (o_position !== want.pos) begin
                $error("position: expected %0d, got %0d", want.pos, o_position);
                fail_count++;
            end
            if (o_remaining !== want.rem) begin
                $error("remaining: expected %0d, got %0d", want.rem, o_remaining);
                fail_count++;
            end
            if (o_status !== want.st) begin
                $error("status: expected %0d, got %0d", want.st, o_status);
                fail_count++;
            end
        end
    endtask

    // Result side: check each beat taken, and stall in runs with quiet stretches between.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_result();
        if (stall_run > 0) begin
            stall_run--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (open_run > 0) begin
                open_run--;
            end else begin
                stall_run = pick_gap();
                open_run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(0, 4);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        // Directed rows: reset state, corner counts, the stream end and error codes.
        dir_rows.push_back(mk_row(OP_TELL, 12'd0, 8'd0, 16'd0, 1, 64'd0, 16'd0, 16'd0, ST_OK));
        dir_rows.push_back(mk_row(OP_GET, 12'd0, 8'd0, 16'd5, 1, 64'd0, 16'd0, 16'd0,
                                  ST_SHORT));
        dir_rows.push_back(mk_row(OP_LOAD, 12'd0, 8'hA5, 16'd0, 1, 64'd0, 16'd0, 16'd0, ST_OK));
        dir_rows.push_back(mk_row(OP_LOAD, 12'd1, 8'hFF, 16'd0, 1, 64'd0, 16'd0, 16'd0, ST_OK));
        dir_rows.push_back(mk_row(OP_LOAD, 12'd2, 8'h00, 16'd0, 1, 64'd0, 16'd0, 16'd0, ST_OK));
        dir_rows.push_back(mk_row(OP_LOAD, 12'd3, 8'h3C, 16'd0, 1, 64'd0, 16'd0, 16'd0, ST_OK));
        dir_rows.push_back(mk_row(OP_LOAD, 12'd4, 8'h81, 16'd0, 1, 64'd0, 16'd0, 16'd0, ST_OK));
        dir_rows.push_back(mk_row(OP_LOAD, 12'd5, 8'h7E, 16'd0, 1, 64'd0, 16'd0, 16'd0, ST_OK));
        dir_rows.push_back(mk_row(OP_LOAD, 12'd6, 8'hC3, 16'd0, 1, 64'd0, 16'd0, 16'd0, ST_OK));
        dir_rows.push_back(mk_row(OP_LOAD, 12'd7, 8'h5A, 16'd0, 1, 64'd0, 16'd0, 16'd0, ST_OK));
        dir_rows.push_back(mk_row(OP_LOAD, 12'd8, 8'h96, 16'd0, 1, 64'd0, 16'd0, 16'd0, ST_OK));
        dir_rows.push_back(mk_row(OP_LOAD, 12'hFFF, 8'hFF, 16'hFFFF, 1, 64'd0, 16'd0, 16'd0,
                                  ST_OK));
        dir_rows.push_back(mk_row(OP_SETLEN, 12'd0, 8'd0, 16'd72, 1, 64'd0, 16'd0, 16'd72,
                                  ST_OK));
        dir_rows.push_back(mk_row(OP_GET, 12'd0, 8'd0, 16'd3, 1, 64'd5, 16'd3, 16'd69, ST_OK));
        dir_rows.push_back(mk_row(OP_PEEK, 12'd0, 8'd0, 16'd64, 0, '0, '0, '0, ST_OK));
        dir_rows.push_back(mk_row(OP_GET, 12'd0, 8'd0, 16'd65, 1, 64'd0, 16'd3, 16'd69,
                                  ST_INVALID));
        dir_rows.push_back(mk_row(OP_GET, 12'd0, 8'd0, 16'd64, 0, '0, '0, '0, ST_OK));
        dir_rows.push_back(mk_row(OP_SEEK, 12'd0, 8'd0, 16'd73, 1, 64'd0, 16'd67, 16'd5,
                                  ST_INVALID));
        dir_rows.push_back(mk_row(OP_PEEK, 12'd0, 8'd0, 16'd9, 0, '0, '0, '0, ST_OK));
        dir_rows.push_back(mk_row(OP_GET, 12'd0, 8'd0, 16'd9, 0, '0, '0, '0, ST_OK));
        dir_rows.push_back(mk_row(OP_SETLEN, 12'd0, 8'd0, 16'd61, 1, 64'd0, 16'd0, 16'd61,
                                  ST_OK));
        dir_rows.push_back(mk_row(OP_SKIP, 12'd0, 8'd0, 16'd70, 1, 64'd61, 16'd61, 16'd0,
                                  ST_OK));
        dir_rows.push_back(mk_row(OP_SEEK, 12'd0, 8'd0, 16'd56, 1, 64'd0, 16'd56, 16'd5,
                                  ST_OK));
        dir_rows.push_back(mk_row(OP_GET, 12'd0, 8'd0, 16'd0, 1, 64'd0, 16'd56, 16'd5, ST_OK));
        dir_rows.push_back(mk_row(OP_GET, 12'd0, 8'd0, 16'd8, 0, '0, '0, '0, ST_OK));
        dir_rows.push_back(mk_row(OP_SETLEN, 12'd0, 8'd0, 16'hFFFF, 1, 64'd0, 16'd0,
                                  16'd32768, ST_OK));
        dir_rows.push_back(mk_row(OP_SEEK, 12'd0, 8'd0, 16'd32768, 1, 64'd0, 16'd32768,
                                  16'd0, ST_OK));
        dir_rows.push_back(mk_row(OP_UNDEF, 12'd0, 8'd0, 16'd0, 1, 64'd0, 16'd32768, 16'd0,
                                  ST_INVALID));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_beat(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
        while (prefix_bytes < BUF_BYTES && byte_known[prefix_bytes]) prefix_bytes++;

        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS) run_session();
        i_in_valid <= 1'b0;

        // Let every outstanding result come back, then a short quiet tail.
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/mbru_pkg.sv
src/mbru_store.sv
src/mbru_extract.sv
src/msb_first_bit_reader_unit.sv
tb/sv/tb_top.sv
